>>> hw/rtl/complementary_tilt_filter_assert.svh
// Assertion macros used by the checker file.
`ifndef COMPLEMENTARY_TILT_FILTER_ASSERT_SVH
`define COMPLEMENTARY_TILT_FILTER_ASSERT_SVH
`define CTF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define CTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

>>> hw/rtl/ctf_pkg.sv
// Package with shared types, constants and tables of the tilt filter.
package ctf_pkg;
	localparam int CordicStepsDefault = 16;
	localparam int FracBitsDefault = 16;
	localparam int MaxSteps = 24;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 32;

	localparam logic [CfgIdxW-1:0] REG_BLEND = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_OFFSET = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_ROLL_BIAS = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_YAW_BIAS = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_RESET_STEP = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_FIRST_STEP = 3'd5;

	localparam logic signed [34:0] PiQ30 = 35'sd3373259426;

	typedef struct packed {
		logic signed [31:0] accel_y;
		logic signed [31:0] accel_z;
		logic signed [31:0] gyro_roll;
		logic signed [31:0] gyro_yaw;
		logic [31:0] time_ms;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] tilt_angle;
		logic signed [31:0] tilt_rate;
		logic signed [31:0] yaw_angle;
	} result_t;

	// Classified item handed from front to back.
	typedef struct packed {
		logic signed [31:0] accel_y;
		logic signed [31:0] accel_z;
		logic signed [31:0] rate_x;
		logic signed [31:0] rate_y;
		logic [31:0] step_ms;
		logic snap;
	} job_t;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sd2147483647) return 32'sh7fffffff;
		if (v < -34'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		case (i)
			5'd0: return 32'd843314857;
			5'd1: return 32'd497837829;
			5'd2: return 32'd263043836;
			5'd3: return 32'd133525158;
			5'd4: return 32'd67021686;
			5'd5: return 32'd33543515;
			5'd6: return 32'd16775850;
			5'd7: return 32'd8388437;
			5'd8: return 32'd4194282;
			5'd9: return 32'd2097149;
			5'd10: return 32'd1048575;
			5'd11: return 32'd524287;
			5'd12: return 32'd262143;
			5'd13: return 32'd131071;
			5'd14: return 32'd65535;
			5'd15: return 32'd32767;
			5'd16: return 32'd16383;
			5'd17: return 32'd8191;
			5'd18: return 32'd4095;
			5'd19: return 32'd2047;
			5'd20: return 32'd1023;
			5'd21: return 32'd511;
			5'd22: return 32'd255;
			5'd23: return 32'd127;
			default: return 32'd0;
		endcase
	endfunction
endpackage

>>> hw/rtl/ctf_stream_if.sv
// Valid/ready stream interface used by the sample and result channels.
interface ctf_stream_if #(parameter type payload_t = logic [31:0]);
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/ctf_front.sv
// Front part: biases rates, computes the step and the snap decision.
module ctf_front
	import ctf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input sample_t in_data,
	input logic signed [17:0] roll_bias,
	input logic signed [17:0] yaw_bias,
	input logic [9:0] reset_step,
	input logic [9:0] first_step,
	output logic job_valid,
	input logic job_ready,
	output job_t job_data
);
	logic [31:0] last_stamp_q;
	logic stamp_valid_q;
	logic [31:0] step;
	logic take;

	assign in_ready = job_ready;
	assign job_valid = in_valid;
	assign take = in_valid && job_ready;
	assign step = stamp_valid_q ? (in_data.time_ms - last_stamp_q) : {22'd0, first_step};

	always_comb begin
		job_data.accel_y = in_data.accel_y;
		job_data.accel_z = in_data.accel_z;
		job_data.rate_x = sat32(34'(in_data.gyro_roll) + 34'(roll_bias));
		job_data.rate_y = sat32(34'(in_data.gyro_yaw) + 34'(yaw_bias));
		job_data.step_ms = step;
		job_data.snap = step > {22'd0, reset_step};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_stamp_q <= '0;
			stamp_valid_q <= 1'b0;
		end else if (take) begin
			last_stamp_q <= in_data.time_ms;
			stamp_valid_q <= 1'b1;
		end
	end
endmodule

>>> hw/rtl/ctf_queue.sv
// Two-entry queue between the front and the back part.
module ctf_queue
	import ctf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_ready,
	input job_t wr_data,
	output logic rd_valid,
	input logic rd_ready,
	output job_t rd_data
);
	job_t mem_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic push, pop;

	assign wr_ready = count_q != 2'd2;
	assign rd_valid = count_q != 2'd0;
	assign rd_data = mem_q[rd_ptr_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

>>> hw/rtl/ctf_back.sv
// Back part: CORDIC angle, gyro integration, blend and result register.
module ctf_back
	import ctf_pkg::*;
#(
	parameter int CORDIC_STEPS = CordicStepsDefault,
	parameter int FRAC_BITS = FracBitsDefault
) (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	output logic job_ready,
	input job_t job_data,
	input logic [16:0] blend_weight,
	input logic signed [18:0] tilt_offset,
	output logic out_valid,
	input logic out_ready,
	output result_t out_data
);
	localparam int CntW = $clog2(MaxSteps + 1);
	localparam logic [3:0] ST_IDLE = 4'd0, ST_CORDIC = 4'd1, ST_ANGLE = 4'd2,
		ST_ROUND = 4'd3, ST_HIGH = 4'd4, ST_REM = 4'd5, ST_LOW = 4'd6,
		ST_MERGE = 4'd7, ST_MULT = 4'd8, ST_BLEND = 4'd9, ST_OUT = 4'd10;
	// 2^34 / 125 rounded up; the quotient is exact for dividends below 2^27.
	localparam logic [27:0] Recip125 = 28'd137438954;

	logic [3:0] state_q;
	logic [CntW-1:0] iter_q;
	job_t job_q;
	logic signed [34:0] x_q, y_q, z_q;
	logic signed [33:0] acc_q;
	logic signed [33:0] inc_q;
	logic signed [31:0] tilt_store_q, yaw_store_q;
	logic signed [33:0] base_q;
	logic signed [51:0] mix_a_q, mix_b_q;
	result_t res_q;
	logic res_valid_q;
	logic [1:0][63:0] pm_prod_q;
	logic [1:0] pm_neg_q;
	logic [1:0][41:0] pm_m_q;
	logic [1:0][12:0] pm_q1_q;
	logic [1:0][26:0] pm_c_q;

	logic signed [34:0] xs, ys, zr;
	logic signed [17:0] alpha;
	logic signed [52:0] mix;
	logic [4:0] iter_idx;
	logic res_load;
	logic [1:0][31:0] rate_mag;
	logic [1:0][63:0] pm_sum;
	logic [1:0][46:0] pm_hi_prod;
	logic [1:0][54:0] pm_lo_prod;
	logic [1:0][18:0] pm_rem;
	logic [1:0][32:0] pm_mag;
	logic [1:0][33:0] pm_val;

	assign iter_idx = 5'(iter_q);
	assign xs = x_q >>> iter_q;
	assign ys = y_q >>> iter_q;
	assign zr = z_q + (35'sd1 <<< (29 - FRAC_BITS));
	assign alpha = (blend_weight > 17'd65536) ? 18'sd65536 : $signed({1'b0, blend_weight});
	assign mix = 53'(mix_a_q) + 53'(mix_b_q) + 53'sd32768;

	assign job_ready = (state_q == ST_IDLE);
	assign res_load = (state_q == ST_OUT) && (!res_valid_q || out_ready);
	assign out_valid = res_valid_q;
	assign out_data = res_q;

	// Rounded per-mille, lane 0 for the roll increment and lane 1 for yaw. The magnitude
	// plus 500 (499 for a negative product) is divided by 8 with a shift and by 125 in two
	// reciprocal steps of 19 and 20 bits, then the sign is restored. Magnitudes that would
	// saturate the yaw anyway are clamped below 2^42.
	always_comb begin
		rate_mag[0] = job_q.rate_x[31] ? 32'(-job_q.rate_x) : 32'(job_q.rate_x);
		rate_mag[1] = job_q.rate_y[31] ? 32'(-job_q.rate_y) : 32'(job_q.rate_y);
		for (int k = 0; k < 2; k++) begin
			pm_sum[k] = pm_prod_q[k] + (pm_neg_q[k] ? 64'd499 : 64'd500);
			pm_hi_prod[k] = 47'(pm_m_q[k][41:23]) * 47'(Recip125);
			pm_rem[k] = pm_m_q[k][41:23] - 19'(pm_q1_q[k]) * 19'd125;
			pm_lo_prod[k] = 55'(pm_c_q[k]) * 55'(Recip125);
			pm_mag[k] = {pm_q1_q[k], pm_lo_prod[k][53:34]};
			pm_val[k] = pm_neg_q[k] ? (34'd0 - {1'b0, pm_mag[k]}) : {1'b0, pm_mag[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q <= '0;
			job_q <= '0;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
			acc_q <= '0;
			inc_q <= '0;
			tilt_store_q <= '0;
			yaw_store_q <= '0;
			base_q <= '0;
			mix_a_q <= '0;
			mix_b_q <= '0;
			res_q <= '0;
			res_valid_q <= 1'b0;
			pm_prod_q <= '0;
			pm_neg_q <= '0;
			pm_m_q <= '0;
			pm_q1_q <= '0;
			pm_c_q <= '0;
		end else begin
			if (res_load) res_valid_q <= 1'b1;
			else if (out_ready) res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						job_q <= job_data;
						iter_q <= '0;
						if (job_data.accel_z < 0) begin
							x_q <= -35'(job_data.accel_z);
							y_q <= -35'(job_data.accel_y);
							z_q <= (job_data.accel_y >= 0) ? PiQ30 : -PiQ30;
						end else begin
							x_q <= 35'(job_data.accel_z);
							y_q <= 35'(job_data.accel_y);
							z_q <= '0;
						end
						state_q <= ST_CORDIC;
					end
				end
				ST_CORDIC: begin
					if (y_q > 0) begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + 35'($signed({1'b0, atan_q30(iter_idx)}));
					end else if (y_q < 0) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - 35'($signed({1'b0, atan_q30(iter_idx)}));
					end
					iter_q <= iter_q + 1'b1;
					if (32'(iter_q) == CORDIC_STEPS - 1) state_q <= ST_ANGLE;
				end
				ST_ANGLE: begin
					acc_q <= 34'(zr >>> (30 - FRAC_BITS)) + 34'(tilt_offset);
					pm_prod_q[0] <= 64'(rate_mag[0]) * 64'(job_q.step_ms);
					pm_prod_q[1] <= 64'(rate_mag[1]) * 64'(job_q.step_ms);
					pm_neg_q <= {job_q.rate_y[31], job_q.rate_x[31]};
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					for (int k = 0; k < 2; k++)
						pm_m_q[k] <= (pm_sum[k][63:42] != 22'd0) ? {42{1'b1}} : pm_sum[k][41:0];
					state_q <= ST_HIGH;
				end
				ST_HIGH: begin
					for (int k = 0; k < 2; k++)
						pm_q1_q[k] <= pm_hi_prod[k][46:34];
					state_q <= ST_REM;
				end
				ST_REM: begin
					for (int k = 0; k < 2; k++)
						pm_c_q[k] <= {pm_rem[k][6:0], pm_m_q[k][22:3]};
					state_q <= ST_LOW;
				end
				ST_LOW: begin
					inc_q <= $signed(pm_val[0]);
					yaw_store_q <= sat32(34'(yaw_store_q) + $signed(pm_val[1]));
					state_q <= ST_MERGE;
				end
				ST_MERGE: begin
					base_q <= 34'(tilt_store_q) + inc_q;
					state_q <= ST_MULT;
				end
				ST_MULT: begin
					mix_a_q <= 52'(alpha) * 52'(base_q);
					mix_b_q <= 52'(18'sd65536 - alpha) * 52'(acc_q);
					state_q <= ST_BLEND;
				end
				ST_BLEND: begin
					if (job_q.snap) tilt_store_q <= sat32(acc_q);
					else tilt_store_q <= sat32(34'(mix >>> 16));
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (res_load) begin
						res_q.tilt_angle <= tilt_store_q;
						res_q.tilt_rate <= job_q.rate_x;
						res_q.yaw_angle <= yaw_store_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> hw/rtl/complementary_tilt_filter.sv
// Channel   | Direction | Payload
// sample    | sink      | accel_y, accel_z, gyro_roll, gyro_yaw, time_ms
// result    | source    | tilt_angle, tilt_rate, yaw_angle
// cfg       | sink      | index (3 bit), data (32 bit)
// The back part takes one sample at a time from the queue and holds it through the CORDIC
// iterations, the angle, rounding and the two per-mille divisions, the blend and the
// result load; it takes the next sample only after its result is loaded.
// Reset clears the tilt, yaw and timestamp state; registers return to defaults.
// The front stalls only when the two-entry queue is full; results wait in a register,
// and the back part holds its last state while an earlier result is still unread.
module complementary_tilt_filter
	import ctf_pkg::*;
#(
	parameter int CORDIC_STEPS = CordicStepsDefault,
	parameter int FRAC_BITS = FracBitsDefault
) (
	input logic clk,
	input logic arst_n,
	ctf_stream_if.sink sample,
	ctf_stream_if.source result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CfgIdxW-1:0] cfg_index,
	input logic [CfgDataW-1:0] cfg_data
);
	logic [16:0] blend_q;
	logic signed [18:0] offset_q;
	logic signed [17:0] roll_bias_q, yaw_bias_q;
	logic [9:0] reset_step_q, first_step_q;
	logic fq_valid, fq_ready, qb_valid, qb_ready;
	job_t fq_data, qb_data;
	result_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_q <= 17'd65339;
			offset_q <= 19'sd102944;
			roll_bias_q <= 18'sd2140;
			yaw_bias_q <= 18'sd1566;
			reset_step_q <= 10'd10;
			first_step_q <= 10'd10;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BLEND: blend_q <= cfg_data[16:0];
				REG_OFFSET: offset_q <= cfg_data[18:0];
				REG_ROLL_BIAS: roll_bias_q <= cfg_data[17:0];
				REG_YAW_BIAS: yaw_bias_q <= cfg_data[17:0];
				REG_RESET_STEP: reset_step_q <= cfg_data[9:0];
				REG_FIRST_STEP: first_step_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	ctf_front u_front (
		.clk, .arst_n,
		.in_valid(sample.valid), .in_ready(sample.ready), .in_data(sample.data),
		.roll_bias(roll_bias_q), .yaw_bias(yaw_bias_q),
		.reset_step(reset_step_q), .first_step(first_step_q),
		.job_valid(fq_valid), .job_ready(fq_ready), .job_data(fq_data)
	);

	ctf_queue u_queue (
		.clk, .arst_n,
		.wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
		.rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
	);

	ctf_back #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n,
		.job_valid(qb_valid), .job_ready(qb_ready), .job_data(qb_data),
		.blend_weight(blend_q), .tilt_offset(offset_q),
		.out_valid(result.valid), .out_ready(result.ready), .out_data(res)
	);

	assign result.data = res;
endmodule

>>> hw/rtl/ctf_checker.sv
// Port-level checker for the tilt filter, bound to the top level.
`include "complementary_tilt_filter_assert.svh"
module ctf_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [95:0] out_data,
	input logic cfg_ready
);
	`CTF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`CTF_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_data))
	`CTF_ASSERT_IMPL(a_cfg_ready, clk, arst_n, 1'b1, cfg_ready)
endmodule

bind complementary_tilt_filter ctf_checker u_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(result.valid), .out_ready(result.ready),
	.out_data(result.data), .cfg_ready(cfg_ready)
);

>>> bench/tb.sv
// Self-checking testbench for the complementary tilt filter: random IMU samples, register phases.
module tb;
	import ctf_pkg::*;

	localparam logic [CfgIdxW-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_SPARE_HI = 3'd7;

	// Expected tilt, rate and yaw for each accepted sample, in order of arrival.
	class tilt_scoreboard;
		localparam longint PiQ30Val = 64'sd3373259426;
		longint atan_steps[16] = '{843314857, 497837829, 263043836, 133525158, 67021686,
			33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
			65535, 32767};

		logic [16:0] blend_weight;
		logic signed [18:0] tilt_offset;
		logic signed [17:0] roll_rate_bias;
		logic signed [17:0] yaw_rate_bias;
		logic [9:0] reset_step_ms;
		logic [9:0] first_step_ms;

		logic signed [31:0] tilt_store;
		logic signed [31:0] yaw_store;
		logic [31:0] last_stamp;
		bit stamp_valid;

		result_t expected_results[$];
		int mismatches;
		int checked;
		int snaps;

		function new();
			blend_weight = 17'd65339;
			tilt_offset = 19'sd102944;
			roll_rate_bias = 18'sd2140;
			yaw_rate_bias = 18'sd1566;
			reset_step_ms = 10'd10;
			first_step_ms = 10'd10;
			tilt_store = 0;
			yaw_store = 0;
			last_stamp = 0;
			stamp_valid = 0;
			mismatches = 0;
			checked = 0;
			snaps = 0;
		endfunction

		function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
			case (idx)
				REG_BLEND: blend_weight = value[16:0];
				REG_OFFSET: tilt_offset = value[18:0];
				REG_ROLL_BIAS: roll_rate_bias = value[17:0];
				REG_YAW_BIAS: yaw_rate_bias = value[17:0];
				REG_RESET_STEP: reset_step_ms = value[9:0];
				REG_FIRST_STEP: first_step_ms = value[9:0];
				default: ;
			endcase
		endfunction

		function logic signed [31:0] clamp32(logic signed [95:0] v);
			if (v > 96'sd2147483647)
				return 32'sh7fffffff;
			if (v < -96'sd2147483648)
				return 32'sh80000000;
			return v[31:0];
		endfunction

		// Rounds an integrated rate-times-ms product to whole fixed-point units.
		function logic signed [95:0] ms_to_units(logic signed [95:0] n);
			logic signed [95:0] a;
			logic signed [95:0] q;
			a = n + 96'sd500;
			q = a / 96'sd1000;
			if (a % 96'sd1000 < 0)
				q = q - 1;
			return q;
		endfunction

		function longint cordic_angle(longint y, longint x);
			longint z;
			longint xs;
			longint ys;
			z = 0;
			if (x < 0) begin
				z = (y >= 0) ? PiQ30Val : -PiQ30Val;
				x = -x;
				y = -y;
			end
			for (int i = 0; i < 16; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y > 0) begin
					x = x + ys;
					y = y - xs;
					z = z + atan_steps[i];
				end else if (y < 0) begin
					x = x - ys;
					y = y + xs;
					z = z - atan_steps[i];
				end
			end
			return (z + 64'sd8192) >>> 14;
		endfunction

		function void note_sample(sample_t s);
			result_t r;
			longint rate_x;
			longint rate_y;
			longint acc;
			longint alpha;
			longint base;
			longint mix;
			logic [31:0] d;
			rate_x = clamp32(96'(longint'(s.gyro_roll) + longint'(roll_rate_bias)));
			rate_y = clamp32(96'(longint'(s.gyro_yaw) + longint'(yaw_rate_bias)));
			d = stamp_valid ? s.time_ms - last_stamp : 32'(first_step_ms);
			acc = cordic_angle(longint'(s.accel_y), longint'(s.accel_z)) + longint'(tilt_offset);
			alpha = (blend_weight > 17'd65536) ? 65536 : longint'(blend_weight);
			if (d > 32'(reset_step_ms)) begin
				tilt_store = clamp32(96'(acc));
				snaps++;
			end else begin
				base = longint'(tilt_store)
					+ longint'(ms_to_units(96'(rate_x) * $signed({64'd0, d})));
				mix = alpha * base + (65536 - alpha) * acc + 32768;
				tilt_store = clamp32(96'(mix >>> 16));
			end
			yaw_store = clamp32(96'(yaw_store)
				+ ms_to_units(96'(rate_y) * $signed({64'd0, d})));
			last_stamp = s.time_ms;
			stamp_valid = 1;
			r.tilt_angle = tilt_store;
			r.tilt_rate = rate_x[31:0];
			r.yaw_angle = yaw_store;
			expected_results.push_back(r);
		endfunction

		function void check_result(result_t act);
			result_t exp_r;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result with none expected: %p", act);
				return;
			end
			exp_r = expected_results.pop_front();
			checked++;
			if (exp_r.tilt_angle !== act.tilt_angle || exp_r.tilt_rate !== act.tilt_rate
					|| exp_r.yaw_angle !== act.yaw_angle) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result %0d tilt %0d/%0d rate %0d/%0d yaw %0d/%0d (exp/act)",
						checked, exp_r.tilt_angle, act.tilt_angle, exp_r.tilt_rate,
						act.tilt_rate, exp_r.yaw_angle, act.yaw_angle);
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	ctf_stream_if #(.payload_t(sample_t)) sample_if ();
	ctf_stream_if #(.payload_t(result_t)) result_if ();

	complementary_tilt_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_if),
		.result(result_if),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	tilt_scoreboard sb = new();
	bit sender_idles;
	bit receiver_idles;
	bit long_hold;
	int cycles;
	int samples_sent;
	logic [31:0] clock_ms;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 1500000) begin
			$display("timeout after %0d cycles, %0d results pending", cycles, sb.pending());
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && sample_if.valid && sample_if.ready)
			sb.note_sample(sample_if.data);
		if (arst_n && result_if.valid && result_if.ready)
			sb.check_result(result_if.data);
	end

	// Result side: random stalls, and on request one long hold so the input backs up.
	initial begin
		int gap;
		int held;
		result_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				result_if.ready <= 1'b0;
				held = 0;
				while (held < 400) begin
					@(negedge clk);
					held++;
				end
				long_hold = 0;
			end
			gap = receiver_idles ? $urandom_range(0, 14) : 0;
			if (gap > 0) begin
				result_if.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (!result_if.valid);
		end
	end

	task automatic send_sample(sample_t s);
		int gap;
		gap = sender_idles ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			sample_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_if.data <= s;
		sample_if.valid <= 1'b1;
		do @(posedge clk); while (!sample_if.ready);
		@(negedge clk);
		samples_sent++;
	endtask

	task automatic drain();
		sample_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		// Let any work still in flight settle before registers change.
		repeat (40) @(negedge clk);
	endtask

	// Leaves the write channel valid; the caller drops it after the last transfer.
	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, value);
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return 32'd0;
			3: return 32'($urandom_range(0, 4000)) - 32'd2000;
			4, 5: return 32'($urandom_range(0, 1310720)) - 32'd655360;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] next_stamp();
		case ($urandom_range(0, 19))
			0: return $urandom();
			1: return clock_ms - 32'($urandom_range(1, 50));
			2: return clock_ms + 32'(sb.reset_step_ms);
			3: return clock_ms + 32'(sb.reset_step_ms) + 32'd1;
			default: return clock_ms + 32'($urandom_range(0, 12));
		endcase
	endfunction

	task automatic send_fields(logic [31:0] ay, logic [31:0] az, logic [31:0] gr,
			logic [31:0] gy, logic [31:0] t);
		sample_t s;
		s.accel_y = ay;
		s.accel_z = az;
		s.gyro_roll = gr;
		s.gyro_yaw = gy;
		s.time_ms = t;
		clock_ms = t;
		send_sample(s);
	endtask

	task automatic send_random();
		send_fields(pick_value(), pick_value(), pick_value(), pick_value(), next_stamp());
	endtask

	initial begin
		logic [CfgDataW-1:0] settings[6];
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_if.valid = 1'b0;
		sample_if.data = '0;
		cycles = 0;
		samples_sent = 0;
		clock_ms = 0;
		sender_idles = 1;
		receiver_idles = 1;
		long_hold = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed samples with reset defaults: first sample, zero vector, axis cases.
		send_fields(0, 0, 0, 0, 32'd1000);
		send_fields(0, 32'hfffb0000, 0, 0, 32'd1005);
		send_fields(32'h00010000, 32'hfffb0000, 0, 0, 32'd1010);
		send_fields(32'hffff0000, 32'hfffb0000, 0, 0, 32'd1015);
		send_fields(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'd1025);
		send_fields(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'd1025);
		send_fields(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'd1036);
		send_fields(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000, 32'd1000);
		send_fields(32'h00090000, 32'h00010000, 32'h00020000, 32'hfffe0000, 32'hffffffff);
		send_fields(32'hfff70000, 32'h00000000, 32'h00020000, 32'h00020000, 32'd3);
		send_fields(32'h00000000, 32'h00090000, 32'h55555555, 32'haaaaaaaa, 32'd13);
		send_fields(32'hffffffff, 32'hffffffff, 32'haaaaaaaa, 32'h55555555, 32'd13);
		send_fields(32'h00000001, 32'h00000001, 32'h0000ffff, 32'hffff0000, 32'd20);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: settings = '{32'd0, 32'd205887, 32'd65536, 32'hffff0000, 32'd0, 32'd1000};
				1: settings = '{32'd65536, 32'hfffcdbc1, 32'hffff0000, 32'd65536, 32'd1000,
					32'd1};
				2: settings = '{32'h1ffff, 32'd0, 32'd0, 32'd0, 32'd1023, 32'd0};
				3: settings = '{32'd32768, 32'h3ffff, 32'h1ffff, 32'h20000, 32'd1, 32'd500};
				default: settings = '{$urandom(), $urandom(), $urandom(), $urandom(),
					32'($urandom_range(0, 40)), $urandom()};
			endcase
			write_reg(REG_BLEND, settings[0]);
			write_reg(REG_OFFSET, settings[1]);
			write_reg(REG_ROLL_BIAS, settings[2]);
			write_reg(REG_YAW_BIAS, settings[3]);
			write_reg(REG_RESET_STEP, settings[4]);
			write_reg(REG_FIRST_STEP, settings[5]);
			write_reg(REG_SPARE_LO, $urandom());
			write_reg(REG_SPARE_HI, $urandom());
			cfg_valid <= 1'b0;
			for (int n = 0; n < 225; n++) begin
				if (n % 40 == 0) begin
					sender_idles = $urandom_range(0, 2) != 0;
					receiver_idles = $urandom_range(0, 2) != 0;
				end
				if (n == 60) begin
					sender_idles = 0;
					long_hold = 1;
				end
				if (n == 150)
					drain();
				send_random();
			end
			drain();
		end

		sample_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		$display("Ran %0d samples over six register settings; %0d results compared, %0d snapped.",
			samples_sent, sb.checked, sb.snaps);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("FAILURE");
		end
		$finish;
	end
endmodule
